/* design/qszp_pkg.sv */
// ----------------------------------------------------------------------------
// Quantization parameter package
// Shared widths, register indexes, storage codes, types and code-limit lookup
// for the scale and zero-point pipeline.
// ----------------------------------------------------------------------------
package qszp_pkg;

	// Field widths.
	localparam int IN_W       = 32;
	localparam int SCALE_W    = 56;
	localparam int CODE_W     = 33;
	localparam int DEN_W      = 32;
	localparam int PROD_W     = 64;
	localparam int ERR_W      = 65;
	localparam int BITS_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Default fixed-point formats.
	localparam int DEF_INPUT_FRACTION_BITS = 16;
	localparam int DEF_SCALE_FRACTION_BITS = 40;

	// Divider shape: quotient bits resolved per pipeline stage.
	localparam int DIV_BITS_PER_STAGE = 2;

	// Zero-point quotient clamp at +/- 2^40.
	localparam int                FQ_LOG2  = 40;
	localparam int                MAG_W    = FQ_LOG2 + 1;
	localparam logic [MAG_W-1:0]  FQ_LIMIT = MAG_W'(1) << FQ_LOG2;
	localparam int                ACC_W    = 43;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NARROW_RANGE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_STORAGE = 2'd2;

	// Storage codes.
	localparam logic [1:0] STOR_4B  = 2'd0;
	localparam logic [1:0] STOR_8B  = 2'd1;
	localparam logic [1:0] STOR_16B = 2'd2;
	localparam logic [1:0] STOR_32B = 2'd3;

	typedef struct packed {
		logic [BITS_W-1:0] bit_count;
		logic              narrow_range;
		logic              signed_storage;
	} cfg_t;

	typedef struct packed {
		logic [1:0]               storage;
		logic                     unsup;
		logic signed [CODE_W-1:0] qmin;
		logic signed [CODE_W-1:0] qmax;
	} limits_t;

	// Control and payload that ride alongside the divider lanes.
	typedef struct packed {
		limits_t                  lim;
		logic                     invalid;
		logic                     zero_span;
		logic signed [CODE_W-1:0] q_sel;
		logic [DEN_W-1:0]         diff;
	} side_t;

	// Code limits for the configured storage width.
	function automatic limits_t code_limits(cfg_t c);
		limits_t l;
		l.unsup   = 1'b0;
		l.storage = STOR_4B;
		l.qmin    = '0;
		l.qmax    = '0;
		if (c.bit_count <= BITS_W'(4)) begin
			l.storage = STOR_4B;
			l.qmin    = c.signed_storage ? -33'sd8 : 33'sd0;
			l.qmax    = c.signed_storage ? 33'sd7 : 33'sd15;
		end else if (c.bit_count <= BITS_W'(8)) begin
			l.storage = STOR_8B;
			l.qmin    = c.signed_storage ? -33'sd128 : 33'sd0;
			l.qmax    = c.signed_storage ? 33'sd127 : 33'sd255;
		end else if (c.bit_count <= BITS_W'(16)) begin
			l.storage = STOR_16B;
			l.qmin    = c.signed_storage ? -33'sd32768 : 33'sd0;
			l.qmax    = c.signed_storage ? 33'sd32767 : 33'sd65535;
		end else if (c.bit_count <= BITS_W'(32)) begin
			l.storage = STOR_32B;
			l.qmin    = c.signed_storage ? -33'sd2147483648 : 33'sd0;
			l.qmax    = c.signed_storage ? 33'sd2147483647 : 33'sd4294967295;
		end else begin
			l.unsup = 1'b1;
		end
		if (c.narrow_range) begin
			l.qmin = l.qmin + 33'sd1;
		end
		return l;
	endfunction

	// Magnitude of a code limit.
	function automatic logic [DEN_W-1:0] mag_code(logic signed [CODE_W-1:0] v);
		logic signed [CODE_W-1:0] n;
		n = -v;
		return v[CODE_W-1] ? n[DEN_W-1:0] : v[DEN_W-1:0];
	endfunction

	// Magnitude of an input endpoint.
	function automatic logic [IN_W-1:0] mag_in(logic signed [IN_W-1:0] v);
		logic [IN_W-1:0] n;
		n = -v;
		return v[IN_W-1] ? n : v;
	endfunction

endpackage

/* design/quant_scale_zero_point_calc.sv */
// ----------------------------------------------------------------------------
// Affine quantization scale and zero-point calculator
// Per-channel scale and zero point from an observed fixed-point range.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries range_min and range_max as
//   signed Q15.16. Output channel (out_valid / out_stall) carries the scale,
//   zero point, code limits, storage code and the two error flags.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) set the
//   bit count, narrow range and signed storage; write only while idle.
//   cfg_ready is always high.
// Timing:
//   One transaction per cycle in steady state while no result is stalled. A
//   range passes through 4 front stages, the 32-stage divider (2 quotient
//   bits per stage over a 64-bit dividend) and 3 back stages.
// Reset:
//   Clears all valid bits and the input skid entry; registers return to
//   bit count 8, full range, signed storage.
// Stall:
//   A stalled result holds in the output register and the pipeline freezes.
//   One more input transaction lands in a skid entry, after which in_stall
//   is raised until the pipeline moves again.
// ----------------------------------------------------------------------------
module quant_scale_zero_point_calc import qszp_pkg::*; #(
	parameter int INPUT_FRACTION_BITS = DEF_INPUT_FRACTION_BITS,
	parameter int SCALE_FRACTION_BITS = DEF_SCALE_FRACTION_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [IN_W-1:0]   range_min,
	input  logic signed [IN_W-1:0]   range_max,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [SCALE_W-1:0]       scale_value,
	output logic signed [CODE_W-1:0] zero_point,
	output logic signed [CODE_W-1:0] code_low,
	output logic signed [CODE_W-1:0] code_high,
	output logic [1:0]               storage_code,
	output logic                     unsupported,
	output logic                     invalid_order
);

	localparam int KP = (SCALE_FRACTION_BITS > INPUT_FRACTION_BITS) ?
		SCALE_FRACTION_BITS - INPUT_FRACTION_BITS : 0;
	localparam int DIV_W = (IN_W + KP > PROD_W) ? IN_W + KP : PROD_W;
	localparam int SIDE_W = $bits(side_t);

	// Configuration registers.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_count      <= BITS_W'(8);
			cfg_q.narrow_range   <= 1'b0;
			cfg_q.signed_storage <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BIT_COUNT:      cfg_q.bit_count      <= cfg_data[BITS_W-1:0];
				CFG_NARROW_RANGE:   cfg_q.narrow_range   <= cfg_data[0];
				CFG_SIGNED_STORAGE: cfg_q.signed_storage <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline advance and input skid entry.
	logic                   en;
	logic                   accept;
	logic                   skid_full_q;
	logic signed [IN_W-1:0] skid_min_q, skid_max_q;
	logic                   f_valid;
	logic signed [IN_W-1:0] f_min, f_max;

	assign en       = !(out_valid && out_stall);
	assign in_stall = skid_full_q;
	assign accept   = in_valid && !skid_full_q;
	assign f_valid  = skid_full_q || in_valid;
	assign f_min    = skid_full_q ? skid_min_q : range_min;
	assign f_max    = skid_full_q ? skid_max_q : range_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (en) begin
			skid_full_q <= 1'b0;
		end else if (accept) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !en) begin
			skid_min_q <= range_min;
			skid_max_q <= range_max;
		end
	end

	// Front stages.
	logic              fr_valid;
	logic [DIV_W-1:0]  scale_num, zero_num;
	logic [DEN_W-1:0]  scale_den, zero_den;
	logic              zero_neg;
	side_t             fr_side;

	qszp_front #(
		.INPUT_FRACTION_BITS(INPUT_FRACTION_BITS),
		.SCALE_FRACTION_BITS(SCALE_FRACTION_BITS),
		.DIV_W              (DIV_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (f_valid),
		.range_min(f_min),
		.range_max(f_max),
		.cfg      (cfg_q),
		.out_valid(fr_valid),
		.scale_num(scale_num),
		.scale_den(scale_den),
		.zero_num (zero_num),
		.zero_den (zero_den),
		.zero_neg (zero_neg),
		.side     (fr_side)
	);

	// Divider lanes, running in lockstep.
	logic              dv_valid;
	logic [DIV_W-1:0]  quot_scale, quot_zero;
	logic [DEN_W-1:0]  rem_zero;
	logic [SIDE_W-1:0] dv_side;
	logic              dv_neg;

	qszp_div #(
		.DW (DIV_W),
		.VW (DEN_W),
		.BPS(DIV_BITS_PER_STAGE),
		.SW (SIDE_W)
	) u_div_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.dividend (scale_num),
		.divisor  (scale_den),
		.side_in  (fr_side),
		.out_valid(dv_valid),
		.quotient (quot_scale),
		.remainder(),
		.side_out (dv_side)
	);

	qszp_div #(
		.DW (DIV_W),
		.VW (DEN_W),
		.BPS(DIV_BITS_PER_STAGE),
		.SW (1)
	) u_div_zero (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.dividend (zero_num),
		.divisor  (zero_den),
		.side_in  (zero_neg),
		.out_valid(),
		.quotient (quot_zero),
		.remainder(rem_zero),
		.side_out (dv_neg)
	);

	// Back stages and output register.
	qszp_post #(
		.INPUT_FRACTION_BITS(INPUT_FRACTION_BITS),
		.SCALE_FRACTION_BITS(SCALE_FRACTION_BITS),
		.DIV_W              (DIV_W)
	) u_post (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (dv_valid),
		.quot_scale   (quot_scale),
		.quot_zero    (quot_zero),
		.rem_zero     (rem_zero),
		.zero_neg     (dv_neg),
		.side         (side_t'(dv_side)),
		.out_valid    (out_valid),
		.scale_value  (scale_value),
		.zero_point   (zero_point),
		.code_low     (code_low),
		.code_high    (code_high),
		.storage_code (storage_code),
		.unsupported  (unsupported),
		.invalid_order(invalid_order)
	);

endmodule

/* design/qszp_front.sv */
// ----------------------------------------------------------------------------
// Front stages
// Span and code limits, error-term products, error sums and endpoint choice;
// produces the operands of both divider lanes.
// ----------------------------------------------------------------------------
module qszp_front import qszp_pkg::*; #(
	parameter int INPUT_FRACTION_BITS = DEF_INPUT_FRACTION_BITS,
	parameter int SCALE_FRACTION_BITS = DEF_SCALE_FRACTION_BITS,
	parameter int DIV_W               = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [IN_W-1:0]  range_min,
	input  logic signed [IN_W-1:0]  range_max,
	input  cfg_t                    cfg,
	output logic                    out_valid,
	output logic [DIV_W-1:0]        scale_num,
	output logic [DEN_W-1:0]        scale_den,
	output logic [DIV_W-1:0]        zero_num,
	output logic [DEN_W-1:0]        zero_den,
	output logic                    zero_neg,
	output side_t                   side
);

	localparam int KP = (SCALE_FRACTION_BITS > INPUT_FRACTION_BITS) ?
		SCALE_FRACTION_BITS - INPUT_FRACTION_BITS : 0;

	// Stage 1: span, code limits and code span.
	logic                     v_s1;
	logic signed [IN_W-1:0]   rmin_s1, rmax_s1;
	logic signed [IN_W:0]     diff_s1;
	limits_t                  lim_s1;
	logic [DEN_W-1:0]         den_s1;
	limits_t                  lim_c;
	logic signed [CODE_W-1:0] den_c;

	assign lim_c = code_limits(cfg);
	assign den_c = lim_c.qmax - lim_c.qmin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rmin_s1 <= range_min;
			rmax_s1 <= range_max;
			diff_s1 <= (IN_W+1)'(range_max) - (IN_W+1)'(range_min);
			lim_s1  <= lim_c;
			den_s1  <= den_c[DEN_W-1:0];
		end
	end

	// Stage 2: the four error-term products.
	logic                   v_s2;
	logic [PROD_W-1:0]      pmin_s2, pmax_s2, cmin_s2, cmax_s2;
	logic                   nmin_s2, nmax_s2;
	logic                   invalid_s2, zspan_s2;
	limits_t                lim_s2;
	logic [DEN_W-1:0]       den_s2, diff_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pmin_s2    <= PROD_W'(mag_code(lim_s1.qmin)) * PROD_W'(diff_s1[DEN_W-1:0]);
			pmax_s2    <= PROD_W'(mag_code(lim_s1.qmax)) * PROD_W'(diff_s1[DEN_W-1:0]);
			cmin_s2    <= PROD_W'(mag_in(rmin_s1)) * PROD_W'(den_s1);
			cmax_s2    <= PROD_W'(mag_in(rmax_s1)) * PROD_W'(den_s1);
			nmin_s2    <= rmin_s1[IN_W-1];
			nmax_s2    <= rmax_s1[IN_W-1];
			invalid_s2 <= diff_s1[IN_W];
			zspan_s2   <= (diff_s1 == '0);
			lim_s2     <= lim_s1;
			den_s2     <= den_s1;
			diff_s2    <= diff_s1[DEN_W-1:0];
		end
	end

	// Stage 3: error sums for both endpoints.
	logic                   v_s3;
	logic [ERR_W-1:0]       emin_s3, emax_s3;
	logic [PROD_W-1:0]      cmin_s3, cmax_s3;
	logic                   nmin_s3, nmax_s3;
	logic                   invalid_s3, zspan_s3;
	limits_t                lim_s3;
	logic [DEN_W-1:0]       den_s3, diff_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			emin_s3    <= {1'b0, pmin_s2} + {1'b0, cmin_s2};
			emax_s3    <= {1'b0, pmax_s2} + {1'b0, cmax_s2};
			cmin_s3    <= cmin_s2;
			cmax_s3    <= cmax_s2;
			nmin_s3    <= nmin_s2;
			nmax_s3    <= nmax_s2;
			invalid_s3 <= invalid_s2;
			zspan_s3   <= zspan_s2;
			lim_s3     <= lim_s2;
			den_s3     <= den_s2;
			diff_s3    <= diff_s2;
		end
	end

	// Stage 4: pick the endpoint with the smaller error; a tie takes the maximum.
	logic use_min;

	assign use_min = (emin_s3 < emax_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scale_num      <= DIV_W'(diff_s3) << KP;
			scale_den      <= den_s3;
			zero_num       <= DIV_W'(use_min ? cmin_s3 : cmax_s3);
			zero_den       <= (diff_s3 == '0) ? DEN_W'(1) : diff_s3;
			zero_neg       <= use_min ? nmin_s3 : nmax_s3;
			side.lim       <= lim_s3;
			side.invalid   <= invalid_s3;
			side.zero_span <= zspan_s3;
			side.q_sel     <= use_min ? lim_s3.qmin : lim_s3.qmax;
			side.diff      <= diff_s3;
		end
	end

endmodule

/* design/qszp_div.sv */
// ----------------------------------------------------------------------------
// Pipelined divider
// Unsigned restoring division resolving a few quotient bits per stage, with
// a sideband that travels in step with the operands.
// ----------------------------------------------------------------------------
module qszp_div import qszp_pkg::*; #(
	parameter int DW  = 64,
	parameter int VW  = DEN_W,
	parameter int BPS = DIV_BITS_PER_STAGE,
	parameter int SW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder,
	output logic [SW-1:0] side_out
);

	localparam int STAGES = (DW + BPS - 1) / BPS;
	localparam int PW     = STAGES * BPS;

	// Register after stage g.
	logic          v_s   [STAGES];
	logic [PW-1:0] num_s [STAGES];
	logic [VW-1:0] rem_s [STAGES];
	logic [VW-1:0] div_s [STAGES];
	logic [SW-1:0] side_s[STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic          v_i;
		logic [PW-1:0] num_i, num_n;
		logic [VW-1:0] rem_i, rem_n, div_i;
		logic [SW-1:0] side_i;

		if (g == 0) begin : g_first
			assign v_i    = in_valid;
			assign num_i  = PW'(dividend);
			assign rem_i  = '0;
			assign div_i  = divisor;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i    = v_s[g-1];
			assign num_i  = num_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign div_i  = div_s[g-1];
			assign side_i = side_s[g-1];
		end

		// Shift in one dividend bit, subtract when it fits, for each quotient bit.
		always_comb begin
			logic [VW:0] trial;
			num_n = num_i;
			rem_n = rem_i;
			trial = '0;
			for (int b = 0; b < BPS; b++) begin
				trial = {rem_n, num_n[PW-1]};
				num_n = {num_n[PW-2:0], 1'b0};
				if (trial >= {1'b0, div_i}) begin
					trial    = trial - {1'b0, div_i};
					num_n[0] = 1'b1;
				end
				rem_n = trial[VW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[g]  <= num_n;
				rem_s[g]  <= rem_n;
				div_s[g]  <= div_i;
				side_s[g] <= side_i;
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign quotient  = num_s[STAGES-1][DW-1:0];
	assign remainder = rem_s[STAGES-1];
	assign side_out  = side_s[STAGES-1];

endmodule

/* design/qszp_post.sv */
// ----------------------------------------------------------------------------
// Back stages
// Scale alignment and saturation, floor correction, clamping and rounding of
// the zero point, and the special cases; ends in the output register.
// ----------------------------------------------------------------------------
module qszp_post import qszp_pkg::*; #(
	parameter int INPUT_FRACTION_BITS = DEF_INPUT_FRACTION_BITS,
	parameter int SCALE_FRACTION_BITS = DEF_SCALE_FRACTION_BITS,
	parameter int DIV_W               = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [DIV_W-1:0]         quot_scale,
	input  logic [DIV_W-1:0]         quot_zero,
	input  logic [DEN_W-1:0]         rem_zero,
	input  logic                     zero_neg,
	input  side_t                    side,
	output logic                     out_valid,
	output logic [SCALE_W-1:0]       scale_value,
	output logic signed [CODE_W-1:0] zero_point,
	output logic signed [CODE_W-1:0] code_low,
	output logic signed [CODE_W-1:0] code_high,
	output logic [1:0]               storage_code,
	output logic                     unsupported,
	output logic                     invalid_order
);

	localparam int KN = (INPUT_FRACTION_BITS > SCALE_FRACTION_BITS) ?
		INPUT_FRACTION_BITS - SCALE_FRACTION_BITS : 0;
	localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRACTION_BITS;

	// Stage 1: floor correction, quotient clamp, round compare, scale saturation.
	logic                 v_s1;
	logic [MAG_W-1:0]     mag_s1;
	logic                 neg_s1, gt_s1, eq_s1;
	logic [SCALE_W-1:0]   scale_s1;
	side_t                side_s1;
	logic                 frac_c;
	logic [DIV_W:0]       mag_c;
	logic [DEN_W-1:0]     remf_c;
	logic [DEN_W:0]       twice_c;
	logic [DIV_W-1:0]     shifted_c;

	assign frac_c    = zero_neg && (rem_zero != '0);
	assign mag_c     = {1'b0, quot_zero} + (DIV_W+1)'(frac_c);
	assign remf_c    = frac_c ? side.diff - rem_zero : rem_zero;
	assign twice_c   = {remf_c, 1'b0};
	assign shifted_c = quot_scale >> KN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1   <= (mag_c > (DIV_W+1)'(FQ_LIMIT)) ? FQ_LIMIT : mag_c[MAG_W-1:0];
			neg_s1   <= zero_neg;
			gt_s1    <= twice_c > {1'b0, side.diff};
			eq_s1    <= twice_c == {1'b0, side.diff};
			scale_s1 <= (|shifted_c[DIV_W-1:SCALE_W]) ? '1 : shifted_c[SCALE_W-1:0];
			side_s1  <= side;
		end
	end

	// Stage 2: a = q - floor(t / diff).
	logic                     v_s2;
	logic signed [ACC_W-1:0]  acc_s2;
	logic                     gt_s2, eq_s2;
	logic [SCALE_W-1:0]       scale_s2;
	side_t                    side_s2;
	logic signed [ACC_W-1:0]  q_c, m_c;

	assign q_c = ACC_W'(side_s1.q_sel);
	assign m_c = $signed(ACC_W'(mag_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s2   <= neg_s1 ? q_c + m_c : q_c - m_c;
			gt_s2    <= gt_s1;
			eq_s2    <= eq_s1;
			scale_s2 <= scale_s1;
			side_s2  <= side_s1;
		end
	end

	// Stage 3: round half away from zero, clamp, apply special cases.
	logic                    dec_c;
	logic signed [ACC_W-1:0] z_c, lo_c, hi_c, zc_c;

	assign dec_c = gt_s2 || (eq_s2 && (acc_s2 < ACC_W'(1)));
	assign z_c   = acc_s2 - ACC_W'(dec_c);
	assign lo_c  = ACC_W'(side_s2.lim.qmin);
	assign hi_c  = ACC_W'(side_s2.lim.qmax);
	assign zc_c  = (z_c < lo_c) ? lo_c : ((z_c > hi_c) ? hi_c : z_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s2.lim.unsup) begin
				scale_value   <= '0;
				zero_point    <= '0;
				code_low      <= '0;
				code_high     <= '0;
				storage_code  <= STOR_4B;
				unsupported   <= 1'b1;
				invalid_order <= 1'b0;
			end else begin
				code_low      <= side_s2.lim.qmin;
				code_high     <= side_s2.lim.qmax;
				storage_code  <= side_s2.lim.storage;
				unsupported   <= 1'b0;
				invalid_order <= side_s2.invalid;
				if (side_s2.invalid) begin
					scale_value <= '0;
					zero_point  <= '0;
				end else if (side_s2.zero_span) begin
					scale_value <= SCALE_ONE;
					zero_point  <= side_s2.lim.qmin;
				end else begin
					scale_value <= scale_s2;
					zero_point  <= zc_c[CODE_W-1:0];
				end
			end
		end
	end

endmodule

/* design/qszp_checker.sv */
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module qszp_checker import qszp_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cfg_valid,
	input logic                     cfg_ready,
	input logic [CFG_IDX_W-1:0]     cfg_index,
	input logic [CFG_DATA_W-1:0]    cfg_data,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic signed [IN_W-1:0]   range_min,
	input logic signed [IN_W-1:0]   range_max,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [SCALE_W-1:0]       scale_value,
	input logic signed [CODE_W-1:0] zero_point,
	input logic signed [CODE_W-1:0] code_low,
	input logic signed [CODE_W-1:0] code_high,
	input logic [1:0]               storage_code,
	input logic                     unsupported,
	input logic                     invalid_order
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(scale_value) && $stable(zero_point))
		else $error("stalled result changed");

	// An unsupported bit count clears every other field.
	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> scale_value == '0 && zero_point == '0 &&
			code_low == '0 && code_high == '0 && storage_code == STOR_4B && !invalid_order)
		else $error("unsupported result not cleared");

	// A valid zero point lies inside the code range.
	a_zp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !unsupported && !invalid_order |->
			zero_point >= code_low && zero_point <= code_high)
		else $error("zero point outside code range");

	// An inverted range reports no scale or zero point.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid_order |-> scale_value == '0 && zero_point == '0)
		else $error("inverted range reported a scale");

endmodule

bind quant_scale_zero_point_calc qszp_checker u_qszp_checker (.*);

/* sim/qparam_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quantization parameter checker
// Follows the configuration and input channels, predicts the scale, zero
// point and code limits for every accepted range, and compares each result
// transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module qparam_checker import qszp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic signed [IN_W-1:0]   range_min,
	input  logic signed [IN_W-1:0]   range_max,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [SCALE_W-1:0]       scale_value,
	input  logic signed [CODE_W-1:0] zero_point,
	input  logic signed [CODE_W-1:0] code_low,
	input  logic signed [CODE_W-1:0] code_high,
	input  logic [1:0]               storage_code,
	input  logic                     unsupported,
	input  logic                     invalid_order,
	output int                       fail_count,
	output int                       pending,
	output int                       checked
);

	typedef struct {
		logic [SCALE_W-1:0]       scale;
		logic signed [CODE_W-1:0] zp;
		logic signed [CODE_W-1:0] lo;
		logic signed [CODE_W-1:0] hi;
		logic [1:0]               stor;
		logic                     unsup;
		logic                     inv;
	} qparams_t;

	cfg_t     cfg_shadow;
	qparams_t expected_qparams[$];

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Scale, zero point and limits for one observed range.
	function automatic qparams_t predict_qparams(logic signed [IN_W-1:0] mn,
			logic signed [IN_W-1:0] mx, cfg_t c);
		qparams_t     r;
		longint       qlo, qhi, diff, den, t, fq, rem, a, z, qsel, lim;
		logic [127:0] e_lo, e_hi, sc;
		logic         sg;
		r = '{default: 0};
		sg = c.signed_storage;
		lim = longint'(1) << 40;
		if (c.bit_count > 7'd32) begin
			r.unsup = 1'b1;
			return r;
		end
		if (c.bit_count <= 7'd4) begin
			r.stor = STOR_4B;
			qlo = sg ? -8 : 0;
			qhi = sg ? 7 : 15;
		end else if (c.bit_count <= 7'd8) begin
			r.stor = STOR_8B;
			qlo = sg ? -128 : 0;
			qhi = sg ? 127 : 255;
		end else if (c.bit_count <= 7'd16) begin
			r.stor = STOR_16B;
			qlo = sg ? -32768 : 0;
			qhi = sg ? 32767 : 65535;
		end else begin
			r.stor = STOR_32B;
			qlo = sg ? -64'sd2147483648 : 0;
			qhi = sg ? 64'sd2147483647 : 64'sd4294967295;
		end
		if (c.narrow_range)
			qlo = qlo + 1;
		r.lo = qlo[CODE_W-1:0];
		r.hi = qhi[CODE_W-1:0];
		diff = longint'(mx) - longint'(mn);
		if (diff < 0) begin
			r.inv = 1'b1;
			return r;
		end
		if (diff == 0) begin
			r.scale = SCALE_W'(1) << 40;
			z = qlo;
		end else begin
			den = qhi - qlo;
			sc = (128'(diff) << 24) / 128'(den);
			if (sc > 128'((128'(1) << SCALE_W) - 1))
				sc = (128'(1) << SCALE_W) - 1;
			r.scale = sc[SCALE_W-1:0];
			// Pick the endpoint with the smaller error term; a tie goes to the maximum.
			e_lo = 128'(magnitude(qlo)) * 128'(diff) + 128'(magnitude(longint'(mn))) * 128'(den);
			e_hi = 128'(magnitude(qhi)) * 128'(diff) + 128'(magnitude(longint'(mx))) * 128'(den);
			if (e_lo < e_hi) begin
				qsel = qlo;
				t = longint'(mn) * den;
			end else begin
				qsel = qhi;
				t = longint'(mx) * den;
			end
			// Floor division, clamp of the quotient, then half-away rounding.
			fq = t / diff;
			rem = t % diff;
			if (rem < 0) begin
				fq = fq - 1;
				rem = rem + diff;
			end
			if (fq > lim)
				fq = lim;
			if (fq < -lim)
				fq = -lim;
			a = qsel - fq;
			if (rem == 0 || 2 * rem < diff)
				z = a;
			else if (2 * rem > diff)
				z = a - 1;
			else
				z = (a >= 1) ? a : a - 1;
			if (z < qlo)
				z = qlo;
			if (z > qhi)
				z = qhi;
		end
		r.zp = z[CODE_W-1:0];
		return r;
	endfunction

	assign pending = expected_qparams.size();

	// Track the configuration, queue predictions and compare results.
	always @(posedge clk or negedge arst_n) begin
		qparams_t e;
		if (!arst_n) begin
			cfg_shadow <= '{bit_count: 7'd8, narrow_range: 1'b0, signed_storage: 1'b1};
			fail_count = 0;
			checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BIT_COUNT:      cfg_shadow.bit_count <= cfg_data;
					CFG_NARROW_RANGE:   cfg_shadow.narrow_range <= cfg_data[0];
					CFG_SIGNED_STORAGE: cfg_shadow.signed_storage <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_qparams = {expected_qparams,
					predict_qparams(range_min, range_max, cfg_shadow)};
			if (out_valid && !out_stall) begin
				if (expected_qparams.size() == 0) begin
					$display("%0t: result transaction with no expectation waiting", $time);
					fail_count++;
				end else begin
					e = expected_qparams.pop_front();
					checked++;
					if (scale_value !== e.scale || zero_point !== e.zp || code_low !== e.lo ||
							code_high !== e.hi || storage_code !== e.stor ||
							unsupported !== e.unsup || invalid_order !== e.inv) begin
						$display("%0t: expected scale %h zp %0d lo %0d hi %0d stor %0d uns %b inv %b",
							$time, e.scale, e.zp, e.lo, e.hi, e.stor, e.unsup, e.inv);
						$display("%0t: actual   scale %h zp %0d lo %0d hi %0d stor %0d uns %b inv %b",
							$time, scale_value, zero_point, code_low, code_high, storage_code,
							unsupported, invalid_order);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

/* sim/tb_quant_scale_zero_point_calc.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scale and zero-point calculator testbench
// Drives directed and random channel ranges through several register
// settings and idle patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_quant_scale_zero_point_calc;
	import qszp_pkg::*;

	localparam int LATENCY = 40;
	localparam int CYCLE_LIMIT = 600000;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [IN_W-1:0]   range_min;
	logic signed [IN_W-1:0]   range_max;
	logic                     out_valid;
	logic                     out_stall;
	logic [SCALE_W-1:0]       scale_value;
	logic signed [CODE_W-1:0] zero_point;
	logic signed [CODE_W-1:0] code_low;
	logic signed [CODE_W-1:0] code_high;
	logic [1:0]               storage_code;
	logic                     unsupported;
	logic                     invalid_order;
	int                       fail_count;
	int                       pending;
	int                       checked;
	int                       idle_pct;
	int                       stall_pct;
	int                       cycles;
	int                       sent;

	quant_scale_zero_point_calc u_top (.*);

	qparam_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Random backpressure on the result channel.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
	endtask

	// Wait for every expected result, then for the pipeline to drain.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	// One range transaction; valid stays high into the next call unless a gap comes.
	task automatic send_range(logic signed [IN_W-1:0] mn, logic signed [IN_W-1:0] mx);
		logic st;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		range_min <= mn;
		range_max <= mx;
		do begin
			@(negedge clk);
			st = in_stall;
			@(posedge clk);
		end while (st);
		sent++;
	endtask

	task automatic send_random();
		logic [31:0] a, b, w;
		case ($urandom_range(9))
			0: send_range($urandom, $urandom);
			1: begin
				a = $urandom;
				send_range(a, a);
			end
			2: begin
				a = $urandom;
				b = $urandom;
				if ($signed(a) > $signed(b))
					send_range(a, b);
				else if (a != b)
					send_range(b, a);
				else
					send_range(a + 1, a);
			end
			3, 4: begin
				// Small span around zero.
				w = $urandom_range(32'h0004_0000);
				send_range(-$signed(w), $urandom_range(32'h0004_0000));
			end
			default: begin
				a = $urandom;
				b = $urandom >> $urandom_range(31);
				if ($signed(a) > $signed(32'h7FFF_FFFF - b))
					send_range($signed(32'h7FFF_FFFF - b), 32'h7FFF_FFFF);
				else
					send_range(a, a + b);
			end
		endcase
	endtask

	initial begin
		int bit_list[14] = '{0, 4, 8, 16, 32, 33, 127, 1, 5, 9, 17, 31, 64, 12};
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_BIT_COUNT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		range_min <= '0;
		range_max <= '0;
		idle_pct = 0;
		stall_pct = 0;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ranges at the reset settings.
		send_range(32'sh8000_0000, 32'sh7FFF_FFFF);
		send_range(32'sh7FFF_FFFF, 32'sh8000_0000);
		send_range(0, 0);
		send_range(32'sh8000_0000, 32'sh8000_0000);
		send_range(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_range(-32'sh0001_0000, 32'sh0001_0000);
		send_range(0, 32'sh0001_0000);
		send_range(-32'sh0001_0000, 0);
		send_range(-32'sh0000_8000, 32'sh0000_7F00);
		send_range(32'sh0001_0000, 32'sh0002_0000);
		send_range(-32'sh0002_0000, -32'sh0001_0000);
		send_range(0, 1);
		send_range(-1, 0);
		send_range(1, 0);
		send_range(-255, 0);
		send_range(-1, 254);
		wait_idle();
		write_reg(CFG_BIT_COUNT, 7'd32);
		write_reg(CFG_SIGNED_STORAGE, 7'd0);
		write_reg(CFG_NARROW_RANGE, 7'd1);
		send_range(32'sh8000_0000, 32'sh7FFF_FFFF);
		send_range(0, 1);
		send_range(-1, 32'sh7FFF_FFFF);
		send_range(5, 5);

		// Random phases across register settings and idle patterns.
		for (int p = 0; p < 14; p++) begin
			wait_idle();
			write_reg(CFG_BIT_COUNT, CFG_DATA_W'(bit_list[p]));
			write_reg(CFG_NARROW_RANGE, CFG_DATA_W'($urandom_range(1)));
			write_reg(CFG_SIGNED_STORAGE, CFG_DATA_W'($urandom_range(1)));
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 52; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 52; end
				default: begin idle_pct = 28; stall_pct = 28; end
			endcase
			repeat (100) send_random();
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (LATENCY) @(posedge clk);
		$display("Sent %0d range transactions and checked %0d results", sent, checked);
		$display("over 16 register settings and four idle and stall patterns.");
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
